// ===== rtl/core/spim_pkg.sv =====
`default_nettype none

package spim_pkg;

	localparam int HALF_PERIOD_WIDTH = 16;
	localparam int DATA_WIDTH        = 16;
	localparam int BIT_IDX_WIDTH     = 4;
	localparam int BYTE_BITS         = 8;
	localparam int CFG_IDX_WIDTH     = 2;

	// configuration register indices
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_SPI_MODE    = 2'd0,
		CFG_LSB_FIRST   = 2'd1,
		CFG_HALF_PERIOD = 2'd2
	} cfg_reg_t;

	localparam logic [BIT_IDX_WIDTH-1:0] LAST_BIT_BYTE = 4'd7;
	localparam logic [BIT_IDX_WIDTH-1:0] LAST_BIT_WORD = 4'd15;
	localparam logic [DATA_WIDTH-1:0]    LOW_BYTE_MASK = 16'h00FF;

endpackage

`default_nettype wire

// ===== rtl/core/spim_if.sv =====
`default_nettype none

// one timebase tick
interface spim_tick_if;
	import spim_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  start_req;
	logic                  word16;
	logic [DATA_WIDTH-1:0] tx_data;
	logic                  miso;
	logic                  cs_request;

	modport source (output valid, start_req, word16, tx_data, miso, cs_request, input ready);
	modport sink   (input valid, start_req, word16, tx_data, miso, cs_request, output ready);
endinterface

// pin levels and status for one tick
interface spim_res_if;
	import spim_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  sclk;
	logic                  mosi;
	logic                  ss_n;
	logic                  busy_res;
	logic                  rx_valid;
	logic [DATA_WIDTH-1:0] rx_data;

	modport source (output valid, sclk, mosi, ss_n, busy_res, rx_valid, rx_data, input ready);
	modport sink   (input valid, sclk, mosi, ss_n, busy_res, rx_valid, rx_data, output ready);
endinterface

// register write channel
interface spim_cfg_if;
	import spim_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_WIDTH-1:0] index;
	logic [DATA_WIDTH-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spi_master_shifter.sv =====
// Channel  Dir  Payload                                              Handshake
// tick     in   start_req, word16, tx_data[15:0], miso, cs_request   valid/ready
// res      out  sclk, mosi, ss_n, busy_res, rx_valid, rx_data[15:0]  valid/ready
// cfg      in   index[1:0], data[15:0]                               valid/ready, ready=1
//
// One tick transaction in every cycle while tick.ready is high; its result is registered and shows in the next cycle.
// The bit timer, bit counter and shift words advance on each accepted tick only.
// tick.ready is low only while a result is held and res.ready is low.
// Reset: mode 0, MSB first, half period of one tick, idle.
// Register writes are taken on any cycle and act from the next tick.
`default_nettype none

module spi_master_shifter (
	input  wire logic   clk,
	input  wire logic   arst_n,
	spim_tick_if.sink   tick,
	spim_res_if.source  res,
	spim_cfg_if.sink    cfg
);
	import spim_pkg::*;

	// configuration
	logic [1:0]                   spi_mode_q;
	logic                         lsb_first_q;
	logic [HALF_PERIOD_WIDTH-1:0] half_period_q;

	// transfer state
	logic                         active_q;
	logic                         wide_q;
	logic                         second_half_q;
	logic [HALF_PERIOD_WIDTH-1:0] tick_count_q;
	logic [BIT_IDX_WIDTH-1:0]     bit_idx_q;
	logic [DATA_WIDTH-1:0]        tx_shift_q;
	logic [DATA_WIDTH-1:0]        rx_shift_q;

	// result register
	logic                  res_valid_q;
	logic                  sclk_q;
	logic                  mosi_q;
	logic                  ss_n_q;
	logic                  busy_q;
	logic                  rx_valid_q;
	logic [DATA_WIDTH-1:0] rx_data_q;

	logic tick_acc;

	// working copy of the state for this tick (start loads it fresh)
	logic                         start_now;
	logic                         act;
	logic                         wide_e;
	logic                         half_e;
	logic [HALF_PERIOD_WIDTH-1:0] cnt_e;
	logic [BIT_IDX_WIDTH-1:0]     bit_e;
	logic [DATA_WIDTH-1:0]        tx_e;
	logic [DATA_WIDTH-1:0]        rx_e;

	logic                         idle_lvl;
	logic                         first_lvl;
	logic [BIT_IDX_WIDTH-1:0]     pos;
	logic [HALF_PERIOD_WIDTH:0]   cnt_inc;
	logic [HALF_PERIOD_WIDTH-1:0] hp_eff;
	logic                         half_end;
	logic                         last_bit;

	// next values
	logic                         active_d;
	logic                         half_d;
	logic [HALF_PERIOD_WIDTH-1:0] cnt_d;
	logic [BIT_IDX_WIDTH-1:0]     bit_d;
	logic [DATA_WIDTH-1:0]        rx_d;
	logic                         sclk_d;
	logic                         mosi_d;
	logic                         done_d;
	logic [DATA_WIDTH-1:0]        rx_out_d;

	assign tick_acc   = tick.valid && tick.ready;
	assign tick.ready = !res_valid_q || res.ready;
	assign cfg.ready  = 1'b1;

	// CPOL is mode bit 1; CPHA=0 shows the active level in the first half
	assign idle_lvl  = spi_mode_q[1];
	assign first_lvl = spi_mode_q[0] ? idle_lvl : !idle_lvl;

	assign start_now = !active_q && tick.start_req;
	assign act       = active_q || start_now;
	assign wide_e    = start_now ? tick.word16 : wide_q;
	assign half_e    = start_now ? 1'b0 : second_half_q;
	assign cnt_e     = start_now ? '0 : tick_count_q;
	assign bit_e     = start_now ? '0 : bit_idx_q;
	assign rx_e      = start_now ? '0 : rx_shift_q;
	assign tx_e      = start_now ? (tick.word16 ? tick.tx_data : (tick.tx_data & LOW_BYTE_MASK))
	                             : tx_shift_q;

	// byte select from bit 3, bit within byte mirrored for MSB first
	assign pos = {bit_e[3], (lsb_first_q ? bit_e[2:0] : ~bit_e[2:0])};

	// zero half period counts as one tick; counter wrap also ends the half
	assign hp_eff   = (half_period_q == '0) ? HALF_PERIOD_WIDTH'(1) : half_period_q;
	assign cnt_inc  = {1'b0, cnt_e} + (HALF_PERIOD_WIDTH+1)'(1);
	assign half_end = cnt_inc[HALF_PERIOD_WIDTH] || (cnt_inc[HALF_PERIOD_WIDTH-1:0] >= hp_eff);
	assign last_bit = bit_e >= (wide_e ? LAST_BIT_WORD : LAST_BIT_BYTE);

	always_comb begin
		active_d = act;
		half_d   = half_e;
		cnt_d    = half_end ? '0 : cnt_inc[HALF_PERIOD_WIDTH-1:0];
		bit_d    = bit_e;
		rx_d     = rx_e;
		done_d   = 1'b0;
		rx_out_d = '0;
		sclk_d   = act ? (half_e ? !first_lvl : first_lvl) : idle_lvl;
		mosi_d   = act ? tx_e[pos] : 1'b0;
		if (half_end) begin
			if (!half_e) begin
				rx_d[pos] = tick.miso;
				half_d    = 1'b1;
			end else begin
				half_d = 1'b0;
				if (last_bit) begin
					done_d   = 1'b1;
					active_d = 1'b0;
					bit_d    = '0;
					if (!wide_e)
						rx_out_d = rx_e & LOW_BYTE_MASK;
					else if (lsb_first_q)
						rx_out_d = rx_e;
					else
						rx_out_d = {rx_e[BYTE_BITS-1:0], rx_e[DATA_WIDTH-1:BYTE_BITS]};
				end else begin
					bit_d = bit_e + BIT_IDX_WIDTH'(1);
				end
			end
		end
	end

	// register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spi_mode_q    <= 2'd0;
			lsb_first_q   <= 1'b0;
			half_period_q <= HALF_PERIOD_WIDTH'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SPI_MODE:    spi_mode_q    <= cfg.data[1:0];
				CFG_LSB_FIRST:   lsb_first_q   <= cfg.data[0];
				CFG_HALF_PERIOD: half_period_q <= cfg.data[HALF_PERIOD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// transfer state, moves only when idle ticks leave it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			wide_q        <= 1'b0;
			second_half_q <= 1'b0;
			tick_count_q  <= '0;
			bit_idx_q     <= '0;
			tx_shift_q    <= '0;
			rx_shift_q    <= '0;
		end else if (tick_acc && act) begin
			active_q      <= active_d;
			wide_q        <= wide_e;
			second_half_q <= half_d;
			tick_count_q  <= cnt_d;
			bit_idx_q     <= bit_d;
			tx_shift_q    <= tx_e;
			rx_shift_q    <= rx_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick_acc) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			sclk_q     <= sclk_d;
			mosi_q     <= mosi_d;
			ss_n_q     <= !tick.cs_request;
			busy_q     <= act;
			rx_valid_q <= done_d;
			rx_data_q  <= rx_out_d;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.sclk     = sclk_q;
	assign res.mosi     = mosi_q;
	assign res.ss_n     = ss_n_q;
	assign res.busy_res = busy_q;
	assign res.rx_valid = rx_valid_q;
	assign res.rx_data  = rx_data_q;

	// completion only ever reported as part of a busy tick
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && rx_valid_q |-> busy_q)
		else $error("rx_valid without busy_res");

	// received word is zero unless a transfer completes
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !rx_valid_q |-> rx_data_q == '0)
		else $error("rx_data not zero outside completion");

	// bit counter parked at zero between transfers
	a_idle_bit: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> bit_idx_q == '0)
		else $error("bit counter not cleared while idle");

	// byte transfer never reaches the second byte
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && !wide_q |-> !bit_idx_q[3])
		else $error("bit counter beyond byte");

	// a start on an idle tick always leaves a transfer running
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc && !active_q && tick.start_req |=> active_q)
		else $error("start did not begin a transfer");

endmodule

`default_nettype wire

// ===== tb/spi_master_shifter_test.sv =====
`timescale 1ns / 100ps

module spi_master_shifter_test;
	import spim_pkg::*;

	// Pin levels and status the block reports for one tick
	typedef struct packed {
		logic                  sclk;
		logic                  mosi;
		logic                  ss_n;
		logic                  busy;
		logic                  rx_valid;
		logic [DATA_WIDTH-1:0] rx_data;
	} pins_t;

	typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

	// One line of the stimulus plan: either a register write or a run of identical ticks.
	// 'typed' rows carry a hand-written expectation in 'want' instead of the predicted one.
	typedef struct packed {
		row_kind_t             kind;
		cfg_reg_t              reg_sel;
		logic [DATA_WIDTH-1:0] value;
		logic [7:0]            rep;
		logic                  start;
		logic                  w16;
		logic [DATA_WIDTH-1:0] txd;
		logic                  miso;
		logic                  cs;
		logic                  typed;
		pins_t                 want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	spim_tick_if tick_ch();
	spim_res_if  res_ch();
	spim_cfg_if  cfg_ch();

	spi_master_shifter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop in case the handshakes lock up
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor: own copy of the register file and shifter state
	// ------------------------------------------------------------------
	logic [1:0]            mode_cfg;
	logic                  lsb_cfg;
	logic [DATA_WIDTH-1:0] half_cfg;

	logic [HALF_PERIOD_WIDTH-1:0] ph_count;
	logic                         in_second_half;
	logic [BIT_IDX_WIDTH-1:0]     bit_num;
	logic [DATA_WIDTH-1:0]        tx_word;
	logic [DATA_WIDTH-1:0]        rx_word;
	logic                         xfer_on;
	logic                         xfer_wide;
	logic                         sclk_level;
	logic                         cs_n_level;

	// Advance the shifter by one tick and return the pins it shows on that tick
	function automatic pins_t next_pins(step_t s);
		pins_t                    p;
		logic                     idle_lvl;
		logic                     lead_lvl;
		logic [BIT_IDX_WIDTH-1:0] pos;
		logic [DATA_WIDTH-1:0]    span;
		logic [7:0]               lo;
		logic [7:0]               hi;
		p = '0;
		idle_lvl = mode_cfg[1];
		// CPHA=0 shows the active level in the first half, CPHA=1 the idle one
		lead_lvl = mode_cfg[0] ? idle_lvl : ~idle_lvl;
		cs_n_level = ~s.cs;
		// a start while busy is dropped without looking at the payload
		if (!xfer_on && s.start) begin
			xfer_on        = 1'b1;
			xfer_wide      = s.w16;
			tx_word        = s.w16 ? s.txd : (s.txd & LOW_BYTE_MASK);
			rx_word        = '0;
			bit_num        = '0;
			in_second_half = 1'b0;
			ph_count       = '0;
		end
		if (xfer_on) begin
			// low byte goes first; within a byte the order follows lsb_cfg
			pos = {bit_num[3], lsb_cfg ? bit_num[2:0] : 3'd7 - bit_num[2:0]};
			span = (half_cfg == '0) ? 16'd1 : half_cfg;
			sclk_level = in_second_half ? ~lead_lvl : lead_lvl;
			p.sclk = sclk_level;
			p.mosi = tx_word[pos];
			p.busy = 1'b1;
			ph_count = ph_count + HALF_PERIOD_WIDTH'(1);
			// '>=' so that a half period shortened mid-half ends at once
			if (ph_count == '0 || ph_count >= span) begin
				ph_count = '0;
				if (!in_second_half) begin
					rx_word[pos]   = s.miso;
					in_second_half = 1'b1;
				end else begin
					in_second_half = 1'b0;
					if (bit_num >= (xfer_wide ? LAST_BIT_WORD : LAST_BIT_BYTE)) begin
						lo = rx_word[7:0];
						hi = rx_word[15:8];
						p.rx_valid = 1'b1;
						p.rx_data  = !xfer_wide ? {8'h00, lo} : (lsb_cfg ? {hi, lo} : {lo, hi});
						xfer_on    = 1'b0;
						bit_num    = '0;
						sclk_level = idle_lvl;
					end else begin
						bit_num = bit_num + BIT_IDX_WIDTH'(1);
					end
				end
			end
		end else begin
			sclk_level = idle_lvl;
			p.sclk     = idle_lvl;
			p.mosi     = 1'b0;
		end
		p.ss_n = cs_n_level;
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Bookkeeping
	// ------------------------------------------------------------------
	step_t offered[$];    // ticks on the bus, not yet taken
	pins_t pin_queue[$];  // expected pin levels, oldest first
	int    errors;
	int    ticks_sent;
	int    words_done;
	int    writes;
	bit    gaps_on;
	step_t row;
	pins_t due;
	pins_t seen;

	// Directed plan. Columns:
	// kind, reg, value, rep, start, w16, txd, miso, cs, typed, want{sclk,mosi,ss_n,busy,rxv,rxd}
	localparam int PLAN_LEN = 26;
	step_t plan [PLAN_LEN] = '{
		// idle after reset, chip select following the request
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1,
		  '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000}},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1,
		  '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000}},
		// idle clock level in each mode
		'{ROW_WRITE, CFG_SPI_MODE, 16'h2, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1,
		  '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000}},
		'{ROW_WRITE, CFG_SPI_MODE, 16'h3, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1,
		  '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000}},
		'{ROW_WRITE, CFG_SPI_MODE, 16'h1, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1,
		  '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000}},
		'{ROW_WRITE, CFG_SPI_MODE, 16'h0, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		// zero half period behaves as one tick
		'{ROW_WRITE, CFG_HALF_PERIOD, 16'h0, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		// byte start with chip select off; high byte of tx_data must be dropped
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd1, 1'b1, 1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b1,
		  '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000}},
		// start while busy is ignored
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd1, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b0, '0},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd3, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0, '0},
		// mode and bit order changed mid-transfer
		'{ROW_WRITE, CFG_SPI_MODE, 16'h1, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd2, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b1, 1'b0, '0},
		'{ROW_WRITE, CFG_LSB_FIRST, 16'h1, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd2, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		// longest half period, then cut short mid-half
		'{ROW_WRITE, CFG_HALF_PERIOD, 16'hFFFF, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd4, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b1, 1'b0, '0},
		'{ROW_WRITE, CFG_HALF_PERIOD, 16'h1, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd8, 1'b0, 1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b0, '0},
		// 16-bit word in mode 3, MSB first
		'{ROW_WRITE, CFG_SPI_MODE, 16'h3, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, CFG_LSB_FIRST, 16'h0, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, CFG_HALF_PERIOD, 16'h2, 8'd0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd1, 1'b1, 1'b1, 16'h8001, 1'b1, 1'b1, 1'b0, '0},
		'{ROW_TICK, CFG_SPI_MODE, 16'h0, 8'd2, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// Monitor: predict on each accepted tick, check each accepted result.
	// Sampled at the rising edge, before the block's registers update.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready && offered.size() != 0) begin
				row = offered.pop_front();
				due = next_pins(row);
				if (due.rx_valid)
					words_done++;
				pin_queue.push_back(row.typed ? row.want : due);
			end
			if (res_ch.valid && res_ch.ready) begin
				seen = '{res_ch.sclk, res_ch.mosi, res_ch.ss_n, res_ch.busy_res,
				         res_ch.rx_valid, res_ch.rx_data};
				if (pin_queue.size() == 0) begin
					$error("result transaction with nothing outstanding");
					errors++;
				end else begin
					due = pin_queue.pop_front();
					if (seen.sclk !== due.sclk) begin
						$error("sclk: expected %0b, got %0b", due.sclk, seen.sclk);
						errors++;
					end
					if (seen.mosi !== due.mosi) begin
						$error("mosi: expected %0b, got %0b", due.mosi, seen.mosi);
						errors++;
					end
					if (seen.ss_n !== due.ss_n) begin
						$error("ss_n: expected %0b, got %0b", due.ss_n, seen.ss_n);
						errors++;
					end
					if (seen.busy !== due.busy) begin
						$error("busy_res: expected %0b, got %0b", due.busy, seen.busy);
						errors++;
					end
					if (seen.rx_valid !== due.rx_valid) begin
						$error("rx_valid: expected %0b, got %0b", due.rx_valid, seen.rx_valid);
						errors++;
					end
					if (seen.rx_data !== due.rx_data) begin
						$error("rx_data: expected %h, got %h", due.rx_data, seen.rx_data);
						errors++;
					end
				end
			end
		end
	end

	// Result side back-pressure: random stall bursts while gaps are enabled
	initial begin
		res_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 9) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				res_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers: everything changes on the falling edge
	// ------------------------------------------------------------------
	task automatic send_tick(step_t s);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		tick_ch.valid      <= 1'b1;
		tick_ch.start_req  <= s.start;
		tick_ch.word16     <= s.w16;
		tick_ch.tx_data    <= s.txd;
		tick_ch.miso       <= s.miso;
		tick_ch.cs_request <= s.cs;
		offered.push_back(s);
		do @(posedge clk); while (!tick_ch.ready);
		ticks_sent++;
	endtask

	// Drop tick valid and let every outstanding transaction come back
	task automatic wait_drained();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (offered.size() != 0 || pin_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t sel, logic [DATA_WIDTH-1:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= sel;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		case (sel)
			CFG_SPI_MODE:    mode_cfg = v[1:0];
			CFG_LSB_FIRST:   lsb_cfg  = v[0];
			CFG_HALF_PERIOD: half_cfg = v;
			default: ;
		endcase
		writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		step_t                 item;
		int                    n;
		logic                  cs_hold;
		logic [DATA_WIDTH-1:0] hp_pick;

		errors     = 0;
		ticks_sent = 0;
		words_done = 0;
		writes     = 0;
		gaps_on    = 1'b0;
		cs_hold    = 1'b0;

		// reset state of the register file and shifter
		mode_cfg       = 2'd0;
		lsb_cfg        = 1'b0;
		half_cfg       = 16'd1;
		ph_count       = '0;
		in_second_half = 1'b0;
		bit_num        = '0;
		tx_word        = '0;
		rx_word        = '0;
		xfer_on        = 1'b0;
		xfer_wide      = 1'b0;
		sclk_level     = 1'b0;
		cs_n_level     = 1'b1;

		arst_n             = 1'b0;
		tick_ch.valid      = 1'b0;
		tick_ch.start_req  = 1'b0;
		tick_ch.word16     = 1'b0;
		tick_ch.tx_data    = '0;
		tick_ch.miso       = 1'b0;
		tick_ch.cs_request = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = CFG_SPI_MODE;
		cfg_ch.data        = '0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed plan; register rows wait for the pipe to empty first
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(plan[i].reg_sel, plan[i].value);
			end else begin
				repeat (plan[i].rep) send_tick(plan[i]);
			end
		end

		// Random phases: new settings, then a burst of ticks. Phases cut across
		// transfers, so settings also change mid-word. Last stretch runs without gaps.
		while (ticks_sent < 1250) begin
			wait_drained();
			gaps_on = (ticks_sent < 1050) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1))
				write_reg(CFG_SPI_MODE, DATA_WIDTH'($urandom_range(0, 3)));
			if ($urandom_range(0, 1))
				write_reg(CFG_LSB_FIRST, DATA_WIDTH'($urandom_range(0, 1)));
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0, 1:    hp_pick = 16'd1;
					2:       hp_pick = DATA_WIDTH'($urandom_range(2, 4));
					default: hp_pick = DATA_WIDTH'($urandom_range(5, 8));
				endcase
				write_reg(CFG_HALF_PERIOD, hp_pick);
			end
			n = $urandom_range(20, 80);
			repeat (n) begin
				item       = '0;
				item.kind  = ROW_TICK;
				item.rep   = 8'd1;
				item.start = ($urandom_range(0, 11) == 0);
				item.w16   = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 7))
					0:       item.txd = 16'h0000;
					1:       item.txd = 16'hFFFF;
					default: item.txd = DATA_WIDTH'($urandom_range(0, 65535));
				endcase
				item.miso = 1'($urandom_range(0, 1));
				// chip select mostly held, usually raised along with a start
				if ($urandom_range(0, 15) == 0)
					cs_hold = ~cs_hold;
				if (item.start)
					cs_hold = ($urandom_range(0, 5) != 0);
				item.cs = cs_hold;
				send_tick(item);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);

		$display("Sent %0d ticks with %0d register writes; %0d words received.",
		         ticks_sent, writes, words_done);
		$display("Modes 0-3, both bit orders, 8/16-bit words, half periods 0 to 8 and 65535.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/spim_pkg.sv
rtl/core/spim_if.sv
rtl/core/spi_master_shifter.sv
tb/spi_master_shifter_test.sv
